FILE: hw/rtl/lds_pkg.sv
// lds_pkg: shared constants and types for the linear diophantine solver
// no dependencies

package lds_pkg;

  localparam int COEF_WIDTH_DEF = 32;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOSOL = 2'd1;
  localparam logic [1:0] STATUS_ZERO  = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture inputs, set up euclid state
    logic div_start;  // start a divide of r0 by r1 (or |c| by g)
    logic div_c;      // divide operands are |c| and g
    logic step;       // apply quotient to euclid state
    logic mul_start;  // start scaling multiplies
    logic mul_step;   // one partial product step
  } lds_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic zero_coef;
    logic r1_zero;
    logic div_done;
    logic rem_zero;
    logic mul_done;
  } lds_stat_t;

endpackage

FILE: hw/rtl/lds_datapath.sv
// lds_datapath: euclid registers, bit-serial divider and serial multiplier
// depends on lds_pkg

module lds_datapath import lds_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [COEF_WIDTH-1:0]        coef_a,
  input  logic [COEF_WIDTH-1:0]        coef_b,
  input  logic [COEF_WIDTH-1:0]        rhs_c,
  input  lds_cmd_t                     cmd,
  output lds_stat_t                    stat,
  output logic signed [63:0]           res_x,
  output logic signed [63:0]           res_y,
  output logic [31:0]                  res_g
);

  localparam int MW = COEF_WIDTH + 1;           // magnitude width
  localparam int CW = $clog2(MW + 1);
  localparam int SW = COEF_WIDTH + 2;           // bezout coefficient width
  localparam int MCW = $clog2(MW + 1);

  logic [MW-1:0] r0, r1, uc;
  logic signed [SW-1:0] s0, s1, t0, t1;
  logic neg_a, neg_b, neg_c;

  // divider state
  logic [MW-1:0] dvd, dvs, quo, rem;
  logic [CW-1:0] dcnt;
  logic          dbusy;
  logic          ddone;

  // multiplier state
  logic [MW-1:0] mk;
  logic [MCW-1:0] mcnt;

  logic [MW-1:0] abs_a, abs_b, abs_c;
  logic [MW:0]   rem_sh, rem_try;

  assign abs_a = coef_a[COEF_WIDTH-1] ? MW'(-$signed({1'b1, coef_a})) : MW'(coef_a);
  assign abs_b = coef_b[COEF_WIDTH-1] ? MW'(-$signed({1'b1, coef_b})) : MW'(coef_b);
  assign abs_c = rhs_c[COEF_WIDTH-1]  ? MW'(-$signed({1'b1, rhs_c}))  : MW'(rhs_c);

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem, dvd[MW-1]};
  assign rem_try = rem_sh - {1'b0, dvs};

  // done pulses once quotient and remainder are final
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      ddone <= 1'b0;
    end else if (dbusy && dcnt == CW'(MW - 1)) begin
      dbusy <= 1'b0;
      ddone <= 1'b1;
    end else begin
      ddone <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= cmd.div_c ? uc : r0;
      dvs  <= cmd.div_c ? r0 : r1;
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
    end else if (dbusy) begin
      dvd  <= {dvd[MW-2:0], 1'b0};
      dcnt <= dcnt + 1'b1;
      if (!rem_try[MW]) begin
        rem <= rem_try[MW-1:0];
        quo <= {quo[MW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[MW-1:0];
        quo <= {quo[MW-2:0], 1'b0};
      end
    end
  end

  // euclid state update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0 <= abs_a;
      r1 <= abs_b;
      uc <= abs_c;
      neg_a <= coef_a[COEF_WIDTH-1];
      neg_b <= coef_b[COEF_WIDTH-1];
      neg_c <= rhs_c[COEF_WIDTH-1];
      s0 <= SW'(1); s1 <= '0;
      t0 <= '0;     t1 <= SW'(1);
    end else if (cmd.step) begin
      r0 <= r1;
      r1 <= rem;
      s0 <= s1;
      s1 <= SW'(s0 - $signed(SW'(quo) * s1));
      t0 <= t1;
      t1 <= SW'(t0 - $signed(SW'(quo) * t1));
    end
  end

  // shift-add scaling of x0 and y0 by k = |c|/g
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mk   <= quo;
      mcnt <= '0;
    end else if (cmd.mul_step) begin
      mcnt <= mcnt + 1'b1;
      mk   <= {1'b0, mk[MW-1:1]};
    end
  end

  // shifted operands kept 64 bits wide via separate accumulators
  logic signed [63:0] ax, ay;
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ax <= 64'(neg_a ? -s0 : s0);
      ay <= 64'(neg_b ? -t0 : t0);
    end else if (cmd.mul_step) begin
      ax <= ax <<< 1;
      ay <= ay <<< 1;
    end
  end

  logic signed [63:0] sx, sy;
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      sx <= '0;
      sy <= '0;
    end else if (cmd.mul_step && mk[0]) begin
      sx <= sx + ax;
      sy <= sy + ay;
    end
  end

  assign res_x = neg_c ? -sx : sx;
  assign res_y = neg_c ? -sy : sy;
  assign res_g = 32'(r0);

  assign stat.zero_coef = (r0 == '0) || (r1 == '0);
  assign stat.r1_zero   = (r1 == '0);
  assign stat.div_done  = ddone;
  assign stat.rem_zero  = (rem == '0);
  assign stat.mul_done  = (mcnt == MCW'(MW - 1));

endmodule

FILE: hw/rtl/lds_ctrl.sv
// lds_ctrl: sequencing state machine for the solver
// depends on lds_pkg

module lds_ctrl import lds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lds_stat_t stat,
  output lds_cmd_t  cmd,
  output logic [1:0] st_code
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CDIV  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] code, code_next;
  logic       first, first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= STATUS_OK;
      first <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    first_next = 1'b0;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.zero_coef) begin
          code_next  = STATUS_ZERO;
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_CDIV;
          first_next = 1'b1;
        end
      end
      S_CDIV: begin
        // first cycle after a divide: apply step, then continue or finish
        if (first) begin
          cmd.step = 1'b1;
        end else if (!stat.r1_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_c     = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.div_done) begin
          if (!stat.rem_zero) begin
            code_next  = STATUS_NOSOL;
            state_next = S_OUT;
          end else begin
            cmd.mul_start = 1'b1;
            first_next    = 1'b1;
          end
        end else if (first) begin
          cmd.mul_step = 1'b1;
          first_next   = 1'b1;
          if (stat.mul_done) begin
            code_next  = STATUS_OK;
            state_next = S_OUT;
            first_next = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign st_code = code;

endmodule

FILE: hw/rtl/linear_diophantine_solver_core.sv
// linear_diophantine_solver_core: top level, controller plus datapath
// depends on lds_pkg, lds_ctrl, lds_datapath
// sequence: euclid steps, each with one bit-serial divide, then a divide of |c| by g
// for the divisibility check, then serial scaling of the bezout coefficients
// throughput: one item at a time, set by the one-bit-per-cycle divider
// reset: synchronous, returns to idle with no result pending

module linear_diophantine_solver_core import lds_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COEF_WIDTH-1:0] coef_a,
  input  logic [COEF_WIDTH-1:0] coef_b,
  input  logic [COEF_WIDTH-1:0] rhs_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [63:0]    sol_x,
  output logic signed [63:0]    sol_y,
  output logic [31:0]           divisor_g,
  output logic [1:0]            status
);

  lds_cmd_t  cmd;
  lds_stat_t stat;
  logic signed [63:0] rx, ry;
  logic [31:0] rg;
  logic [1:0] code;

  lds_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd, .st_code(code)
  );

  lds_datapath #(.COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk, .rst, .coef_a, .coef_b, .rhs_c, .cmd, .stat,
    .res_x(rx), .res_y(ry), .res_g(rg)
  );

  // output fields per status
  assign status    = code;
  assign sol_x     = (code == STATUS_OK) ? rx : '0;
  assign sol_y     = (code == STATUS_OK) ? ry : '0;
  assign divisor_g = (code == STATUS_ZERO) ? '0 : rg;

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for linear_diophantine_solver_core
// depends on lds_pkg and the core rtl; checks every result item against a bezout predictor
`timescale 1ns / 1ps

module tb;
  import lds_pkg::*;

  localparam int HOLD_CYCLES = 3000;
  localparam int STALL_LIMIT = 40000;
  localparam int N_RANDOM    = 350;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        g;
    logic [1:0]         st;
  } answer_t;

  typedef struct {
    int      a;
    int      b;
    int      c;
    bit      typed;
    answer_t ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] coef_a = '0;
  logic [31:0] coef_b = '0;
  logic [31:0] rhs_c = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [63:0] sol_x;
  logic signed [63:0] sol_y;
  logic [31:0] divisor_g;
  logic [1:0]  status;

  answer_t pending_answers[$];
  answer_t typed_answers[int];
  int      n_accepted = 0;
  int      n_offered = 0;
  int      n_checked = 0;
  int      n_errors = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  bit      hold_req = 1'b0;
  int      idle_cycles = 0;

  linear_diophantine_solver_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .coef_a(coef_a), .coef_b(coef_b), .rhs_c(rhs_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .sol_x(sol_x), .sol_y(sol_y), .divisor_g(divisor_g), .status(status)
  );

  always #6 clk = ~clk;

  // extended euclid on magnitudes, signs fixed afterwards
  function automatic answer_t solve_bezout(int a, int b, int c);
    longint ma, mb, mc, r0, r1, r2, q, s0, s1, s2, t0, t1, t2, k;
    answer_t res;
    ma = (a < 0) ? -longint'(a) : longint'(a);
    mb = (b < 0) ? -longint'(b) : longint'(b);
    mc = (c < 0) ? -longint'(c) : longint'(c);
    res = '{x: 0, y: 0, g: 0, st: STATUS_ZERO};
    if (ma == 0 || mb == 0) return res;
    r0 = ma; r1 = mb; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      s2 = s0 - q * s1;
      t2 = t0 - q * t1;
      r0 = r1; r1 = r2; s0 = s1; s1 = s2; t0 = t1; t1 = t2;
    end
    res.g = r0[31:0];
    if (mc % r0 != 0) begin
      res.st = STATUS_NOSOL;
      return res;
    end
    if (a < 0) s0 = -s0;
    if (b < 0) t0 = -t0;
    k = mc / r0;
    if (c < 0) k = -k;
    res.x = s0 * k;
    res.y = t0 * k;
    res.st = STATUS_OK;
    return res;
  endfunction

  function automatic int rand_sign(int v);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  // random item: shared-factor cases (mostly solvable), zero coefficients, long chains, extreme values and noise
  function automatic row_t random_item();
    row_t r;
    int   kind, gf, fa, fb, idx;
    r.typed = 1'b0;
    r.ans = '0;
    kind = $urandom_range(0, 9);
    gf = $urandom_range(1, 1000);
    case (kind)
      0: begin
        r.a = $urandom; r.b = $urandom; r.c = $urandom;
      end
      1: begin
        r.a = ($urandom_range(0, 1) != 0) ? 0 : $urandom;
        r.b = (r.a != 0) ? 0 : $urandom;
        r.c = $urandom;
      end
      8: begin
        // consecutive fibonacci numbers give the longest euclid chains
        idx = $urandom_range(20, 45);
        fa = 1; fb = 1;
        repeat (idx - 2) begin
          fb = fa + fb;
          fa = fb - fa;
        end
        r.a = rand_sign(fa); r.b = rand_sign(fb); r.c = $urandom;
      end
      9: begin
        r.a = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        r.b = ($urandom_range(0, 2) == 0) ? 32'h8000_0000 : $urandom;
        r.c = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : $urandom;
      end
      default: begin
        r.a = rand_sign(gf * $urandom_range(1, 2000000));
        r.b = rand_sign(gf * $urandom_range(1, 2000000));
        r.c = rand_sign(gf * $urandom_range(0, 2000000));
        if (kind == 7) r.c = r.c + 1;
      end
    endcase
    return r;
  endfunction

  // offer one item, with a random gap before it
  task automatic offer_item(row_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coef_a <= r.a;
    coef_b <= r.b;
    rhs_c <= r.c;
    if (r.typed) typed_answers[n_offered] = r.ans;
    do @(posedge clk); while (!in_ready);
    n_offered++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // accepted items feed the predictor; results are checked in order
  always @(posedge clk) begin
    answer_t want, got;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        want = solve_bezout(coef_a, coef_b, rhs_c);
        if (typed_answers.exists(n_accepted)) begin
          if (typed_answers[n_accepted] != want) begin
            $error("predictor disagrees with table for item %0d", n_accepted);
            n_errors++;
          end
          want = typed_answers[n_accepted];
        end
        pending_answers.insert(pending_answers.size(), want);
        n_accepted <= n_accepted + 1;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got = '{x: sol_x, y: sol_y, g: divisor_g, st: status};
        if (pending_answers.size() == 0) begin
          $error("result item with none expected");
          n_errors++;
        end else begin
          want = pending_answers.pop_front();
          n_checked++;
          if (got.x !== want.x) begin
            $error("sol_x expected %0d actual %0d", want.x, got.x); n_errors++;
          end
          if (got.y !== want.y) begin
            $error("sol_y expected %0d actual %0d", want.y, got.y); n_errors++;
          end
          if (got.g !== want.g) begin
            $error("divisor_g expected %0d actual %0d", want.g, got.g); n_errors++;
          end
          if (got.st !== want.st) begin
            $error("status expected %0d actual %0d", want.st, got.st); n_errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // directed rows; expected values typed only where obvious
  row_t directed[] = '{
    '{0, 5, 7, 1'b1, '{0, 0, 0, STATUS_ZERO}},
    '{-9, 0, 3, 1'b1, '{0, 0, 0, STATUS_ZERO}},
    '{0, 0, 0, 1'b1, '{0, 0, 0, STATUS_ZERO}},
    '{4, 6, 3, 1'b1, '{0, 0, 2, STATUS_NOSOL}},
    '{3, 5, 0, 1'b1, '{0, 0, 1, STATUS_OK}},
    '{1, 1, 7, 1'b1, '{0, 7, 1, STATUS_OK}},
    '{-1, 1, 7, 0, '0},
    '{1, -1, -7, 0, '0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{0, 1, 32'h8000_0000, STATUS_OK}},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, '0},
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0},
    '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, '0},
    '{32'h8000_0000, 2, 1, 1'b1, '{0, 0, 2, STATUS_NOSOL}},
    '{1134903170, 1836311903, -1, 0, '0},
    '{-1836311903, 1134903170, 32'h7fff_ffff, 0, '0},
    '{240, 46, 2, 0, '0},
    '{-240, -46, -4, 0, '0},
    '{12, 18, 32'h8000_0000, 0, '0},
    '{-1, -1, 32'hffff_ffff, 0, '0},
    '{6, 10, 0, 0, '0}
  };

  // stimulus: directed table, then three idling phases of random items
  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle = 36;
    recv_idle = 87;
    for (i = 0; i < directed.size(); i++) offer_item(directed[i]);
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle = 87;
        recv_idle = 36;
      end
      if (i == 2 * N_RANDOM / 3) begin
        send_idle = 0;
        recv_idle = 0;
        hold_req = 1'b1;
      end
      offer_item(random_item());
    end
    in_valid <= 1'b0;
    while (n_checked < n_offered) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
